// ===== hw/rtl/wprs_pkg.sv =====
// wprs_pkg: shared types, codes and constants for the window pushback rate scaler
// holds the factor constants and the elaboration-time root search for the power table
// no dependencies

package wprs_pkg;

	// default parameter values
	localparam int MAX_ELAPSED_MS_DEF     = 1024;
	localparam int ADJUST_INTERVAL_MS_DEF = 100;
	localparam int RATIO_FRAC_BITS_DEF    = 24;

	// q30 fixed point for the power table
	localparam int            Q30_FRAC   = 30;
	localparam logic [63:0]   Q30_ONE    = 64'd1 << Q30_FRAC;
	localparam logic [63:0]   Q30_MASK   = Q30_ONE - 64'd1;
	localparam int            POW_W      = 61;
	localparam logic [63:0]   POW_CAP    = 64'd1 << 60;
	localparam int            ROOT_W     = 31;

	// multiplier operand and product widths
	localparam int            MUL_W      = 32;
	localparam int            PROD_W     = 2 * MUL_W;

	// field widths
	localparam int            BPS_W      = 32;
	localparam int            TIME_W     = 48;
	localparam int            BYTES_W    = 32;

	// configuration port
	localparam int            CFG_INDEX_W = 1;
	localparam int            CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_TARGET   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_PACING = 1'd1;

	// factor selection codes
	localparam int            NUM_FACTORS = 3;
	localparam int            FACT_W      = 2;
	localparam logic [FACT_W-1:0] FACT_FAST_DECAY = 2'd0;
	localparam logic [FACT_W-1:0] FACT_DECAY      = 2'd1;
	localparam logic [FACT_W-1:0] FACT_GROW       = 2'd2;

	// nearest q30 values of 0.9, 0.95 and 1.05
	localparam logic [ROOT_W-1:0] FACTOR_FAST_DECAY = 31'd966367642;
	localparam logic [ROOT_W-1:0] FACTOR_DECAY      = 31'd1020054733;
	localparam logic [ROOT_W-1:0] FACTOR_GROW       = 31'd1127428915;

	typedef enum logic [3:0] {
		S_FILL_HI,
		S_FILL_LO,
		S_FILL_WR,
		S_IDLE,
		S_DECIDE,
		S_UPD_HI,
		S_UPD_LO,
		S_UPD_WR,
		S_TGT,
		S_TGT_WR
	} wprs_state_t;

	// floor(a * b / 2^30), capped at 2^60
	function automatic logic [63:0] mul_q30_cap(input logic [63:0] a, input logic [ROOT_W-1:0] b);
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] p;
		hi = (a >> Q30_FRAC) * {33'd0, b};
		lo = ((a & Q30_MASK) * {33'd0, b}) >> Q30_FRAC;
		p  = hi + lo;
		return (p > POW_CAP) ? POW_CAP : p;
	endfunction

	// largest q30 root r with r^n (truncating each step) not above f
	function automatic logic [ROOT_W-1:0] q30_root(input logic [ROOT_W-1:0] f, input int n);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		logic [63:0] p;
		lo = 32'd0;
		hi = 32'h8000_0000;
		while ((hi - lo) > 32'd1) begin
			mid = (lo + hi) >> 1;
			p   = Q30_ONE;
			for (int i = 0; i < n; i++) begin
				p = mul_q30_cap(p, mid[ROOT_W-1:0]);
			end
			if (p <= {33'd0, f}) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo[ROOT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/wprs_if.sv =====
// wprs_if: valid/ready channel interfaces for input items and results
// depends on wprs_pkg for field widths

interface wprs_item_if;
	logic                               valid;
	logic                               ready;
	logic [wprs_pkg::BPS_W-1:0]         estimate_bps;
	logic [wprs_pkg::TIME_W-1:0]        time_ms;
	logic [wprs_pkg::BYTES_W-1:0]       in_flight_bytes;
	logic [wprs_pkg::BYTES_W-1:0]       queued_bytes;
	logic [wprs_pkg::BYTES_W-1:0]       window_bytes;

	modport source (
		output valid, estimate_bps, time_ms, in_flight_bytes, queued_bytes, window_bytes,
		input  ready
	);
	modport sink (
		input  valid, estimate_bps, time_ms, in_flight_bytes, queued_bytes, window_bytes,
		output ready
	);
endinterface

interface wprs_result_if #(
	parameter int RATIO_W = wprs_pkg::RATIO_FRAC_BITS_DEF + 1
);
	logic                               valid;
	logic                               ready;
	logic [wprs_pkg::BPS_W-1:0]         target_bps;
	logic [RATIO_W-1:0]                 ratio_now;

	modport source (
		output valid, target_bps, ratio_now,
		input  ready
	);
	modport sink (
		input  valid, target_bps, ratio_now,
		output ready
	);
endinterface

// ===== hw/rtl/window_pushback_rate_scaler.sv =====
// window_pushback_rate_scaler: congestion window pushback on a bitrate estimate
// depends on wprs_pkg and the channel interfaces in wprs_if.sv
// one shared 32x32 multiplier under a small sequencer, power table in a local memory

// channel   dir   beat fields                                             width
// item      in    estimate_bps time_ms in_flight_bytes queued_bytes         32/48/32/32/32
//                 window_bytes
// result    out   target_bps ratio_now                                    32/RATIO_FRAC_BITS+1
// cfg_*     in    cfg_wen cfg_index cfg_data (write only, no handshake)   1/1/32
//
// after reset the block builds the power table, FILL_HI, FILL_LO and FILL_WR per entry for
// each of the three factors, with item.ready low; config writes are taken meanwhile. an item
// then steps IDLE (the only state that takes a beat), DECIDE, TGT and TGT_WR; a ratio update
// adds UPD_HI, UPD_LO (two multiplier passes) and UPD_WR after DECIDE; no window skips TGT.
// the result sits in an output register, so a stalled result beat does not block the next
// item beat; only the final step waits for that register to drain.

module window_pushback_rate_scaler #(
	parameter int MAX_ELAPSED_MS     = wprs_pkg::MAX_ELAPSED_MS_DEF,
	parameter int ADJUST_INTERVAL_MS = wprs_pkg::ADJUST_INTERVAL_MS_DEF,
	parameter int RATIO_FRAC_BITS    = wprs_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [wprs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wprs_pkg::CFG_DATA_W-1:0]     cfg_data,
	wprs_item_if.sink                           item,
	wprs_result_if.source                       result
);

	localparam int RATIO_W   = RATIO_FRAC_BITS + 1;
	localparam int ROM_DEPTH = MAX_ELAPSED_MS + 1;
	localparam int EL_W      = $clog2(ROM_DEPTH);
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;
	localparam logic [EL_W-1:0]    EL_MAX    = EL_W'(MAX_ELAPSED_MS);
	localparam int Q = wprs_pkg::Q30_FRAC;

	// per-millisecond roots of the three factors, found at elaboration
	localparam logic [wprs_pkg::ROOT_W-1:0] ROOT [wprs_pkg::NUM_FACTORS] = '{
		wprs_pkg::q30_root(wprs_pkg::FACTOR_FAST_DECAY, ADJUST_INTERVAL_MS),
		wprs_pkg::q30_root(wprs_pkg::FACTOR_DECAY, ADJUST_INTERVAL_MS),
		wprs_pkg::q30_root(wprs_pkg::FACTOR_GROW, ADJUST_INTERVAL_MS)
	};

	wprs_pkg::wprs_state_t state_q, state_d;

	// config registers
	logic [wprs_pkg::BPS_W-1:0]     min_target_q;
	logic                           count_pacing_q;

	// kept state
	logic [RATIO_W-1:0]             ratio_q;
	logic [wprs_pkg::TIME_W-1:0]    last_time_q;
	logic                           time_known_q;

	// captured item
	logic [wprs_pkg::BPS_W-1:0]     est_q;
	logic [wprs_pkg::TIME_W-1:0]    now_q;
	logic [wprs_pkg::BYTES_W-1:0]   flight_q;
	logic [wprs_pkg::BYTES_W-1:0]   queued_q;
	logic [wprs_pkg::BYTES_W-1:0]   window_q;
	logic                           bypass_q;

	// table build sequencer
	logic [wprs_pkg::FACT_W-1:0]    fill_k_q;
	logic [EL_W-1:0]                fill_e_q;
	logic [wprs_pkg::POW_W-1:0]     prev_q;

	// shared multiplier
	logic [wprs_pkg::MUL_W-1:0]     mul_a;
	logic [wprs_pkg::MUL_W-1:0]     mul_b;
	logic [wprs_pkg::PROD_W-1:0]    prod_q;
	logic [wprs_pkg::PROD_W-1:0]    acc_q;
	logic [wprs_pkg::PROD_W-1:0]    sum_c;

	// power table
	logic [wprs_pkg::POW_W-1:0]     rom_mem [wprs_pkg::NUM_FACTORS][ROM_DEPTH];
	logic [wprs_pkg::POW_W-1:0]     rom_rd_q;
	logic                           rom_we;
	logic                           rom_re;
	logic [wprs_pkg::POW_W-1:0]     fill_p;

	// result register
	logic                           res_valid_q;
	logic [wprs_pkg::BPS_W-1:0]     res_target_q;
	logic [RATIO_W-1:0]             res_ratio_q;

	// decision terms
	logic [wprs_pkg::BYTES_W:0]     total;
	logic [wprs_pkg::BYTES_W+4:0]   ten_total;
	logic [wprs_pkg::BYTES_W+1:0]   two_total;
	logic [wprs_pkg::BYTES_W+1:0]   three_win;
	logic                           no_window;
	logic                           drained;
	logic                           restart;
	logic                           advance;
	logic [wprs_pkg::TIME_W-1:0]    diff;
	logic [EL_W-1:0]                el_sel;
	logic [wprs_pkg::FACT_W-1:0]    k_sel;

	logic                           item_acc;
	logic                           out_free;
	logic                           fill_last;
	logic [wprs_pkg::BPS_W-1:0]     scaled;
	logic [wprs_pkg::BPS_W-1:0]     target_c;
	logic [RATIO_W-1:0]             ratio_upd;

	assign item_acc  = item.valid && item.ready;
	assign out_free  = !res_valid_q || result.ready;
	assign fill_last = (fill_e_q == EL_MAX) && (fill_k_q == wprs_pkg::FACT_GROW);

	// fill test by cross-multiplication
	assign total     = {1'b0, flight_q} + (count_pacing_q ? {1'b0, queued_q} : '0);
	assign ten_total = ({4'd0, total} << 3) + ({4'd0, total} << 1);
	assign two_total = {1'b0, total} << 1;
	assign three_win = ({2'd0, window_q} << 1) + {2'd0, window_q};
	assign no_window = (window_q == '0);
	assign drained   = !no_window && (ten_total < {5'd0, window_q});
	assign restart   = !no_window && !drained && (!time_known_q || (now_q < last_time_q));
	assign advance   = !no_window && !drained && !restart && (now_q > last_time_q);
	assign diff      = now_q - last_time_q;
	assign el_sel    = (diff > wprs_pkg::TIME_W'(MAX_ELAPSED_MS)) ? EL_MAX : diff[EL_W-1:0];

	always_comb begin
		if (two_total > three_win) begin
			k_sel = wprs_pkg::FACT_FAST_DECAY;
		end else if (total > {1'b0, window_q}) begin
			k_sel = wprs_pkg::FACT_DECAY;
		end else begin
			k_sel = wprs_pkg::FACT_GROW;
		end
	end

	// hi product in acc_q, lo product in prod_q
	assign sum_c     = acc_q + {{Q{1'b0}}, prod_q[wprs_pkg::PROD_W-1:Q]};
	assign fill_p    = (sum_c > wprs_pkg::POW_CAP) ? wprs_pkg::POW_CAP[wprs_pkg::POW_W-1:0]
		: sum_c[wprs_pkg::POW_W-1:0];
	assign ratio_upd = (sum_c > wprs_pkg::PROD_W'(RATIO_ONE)) ? RATIO_ONE : sum_c[RATIO_W-1:0];

	// target from est * ratio, raised to the floor but not above est; est itself with no window
	assign scaled = prod_q[RATIO_FRAC_BITS +: wprs_pkg::BPS_W];
	always_comb begin
		if (bypass_q) begin
			target_c = est_q;
		end else if (scaled < min_target_q) begin
			target_c = (est_q < min_target_q) ? est_q : min_target_q;
		end else begin
			target_c = scaled;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wprs_pkg::S_FILL_HI: state_d = wprs_pkg::S_FILL_LO;
			wprs_pkg::S_FILL_LO: state_d = wprs_pkg::S_FILL_WR;
			wprs_pkg::S_FILL_WR: state_d = fill_last ? wprs_pkg::S_IDLE : wprs_pkg::S_FILL_HI;
			wprs_pkg::S_IDLE: begin
				if (item.valid) state_d = wprs_pkg::S_DECIDE;
			end
			wprs_pkg::S_DECIDE: begin
				if (no_window) begin
					state_d = wprs_pkg::S_TGT_WR;
				end else if (advance) begin
					state_d = wprs_pkg::S_UPD_HI;
				end else begin
					state_d = wprs_pkg::S_TGT;
				end
			end
			wprs_pkg::S_UPD_HI: state_d = wprs_pkg::S_UPD_LO;
			wprs_pkg::S_UPD_LO: state_d = wprs_pkg::S_UPD_WR;
			wprs_pkg::S_UPD_WR: state_d = wprs_pkg::S_TGT;
			wprs_pkg::S_TGT:    state_d = wprs_pkg::S_TGT_WR;
			wprs_pkg::S_TGT_WR: begin
				if (out_free) state_d = wprs_pkg::S_IDLE;
			end
			default: state_d = wprs_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands, table strobes, ready
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		rom_we     = 1'b0;
		rom_re     = 1'b0;
		item.ready = 1'b0;
		case (state_q)
			wprs_pkg::S_FILL_HI: begin
				mul_a = wprs_pkg::MUL_W'(prev_q[wprs_pkg::POW_W-1:Q]);
				mul_b = wprs_pkg::MUL_W'(ROOT[fill_k_q]);
			end
			wprs_pkg::S_FILL_LO: begin
				mul_a = wprs_pkg::MUL_W'(prev_q[Q-1:0]);
				mul_b = wprs_pkg::MUL_W'(ROOT[fill_k_q]);
			end
			wprs_pkg::S_FILL_WR: rom_we = 1'b1;
			wprs_pkg::S_IDLE:    item.ready = 1'b1;
			wprs_pkg::S_DECIDE:  rom_re = 1'b1;
			wprs_pkg::S_UPD_HI: begin
				mul_a = wprs_pkg::MUL_W'(ratio_q);
				mul_b = wprs_pkg::MUL_W'(rom_rd_q[wprs_pkg::POW_W-1:Q]);
			end
			wprs_pkg::S_UPD_LO: begin
				mul_a = wprs_pkg::MUL_W'(ratio_q);
				mul_b = wprs_pkg::MUL_W'(rom_rd_q[Q-1:0]);
			end
			wprs_pkg::S_UPD_WR: begin
				mul_a = '0;
			end
			wprs_pkg::S_TGT, wprs_pkg::S_TGT_WR: begin
				// held through the final step so prod_q stays put while the output stalls
				mul_a = est_q;
				mul_b = wprs_pkg::MUL_W'(ratio_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// control and kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= wprs_pkg::S_FILL_HI;
			min_target_q   <= '0;
			count_pacing_q <= 1'b0;
			ratio_q        <= RATIO_ONE;
			last_time_q    <= '0;
			time_known_q   <= 1'b0;
			fill_k_q       <= wprs_pkg::FACT_FAST_DECAY;
			fill_e_q       <= EL_W'(1);
			prev_q         <= wprs_pkg::Q30_ONE[wprs_pkg::POW_W-1:0];
			res_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wen) begin
				case (cfg_index)
					wprs_pkg::REG_MIN_TARGET:   min_target_q   <= cfg_data;
					wprs_pkg::REG_COUNT_PACING: count_pacing_q <= cfg_data[0];
					default: ;
				endcase
			end

			// table build: step through entries, then the next factor
			if (state_q == wprs_pkg::S_FILL_WR) begin
				if (fill_e_q == EL_MAX) begin
					fill_k_q <= fill_k_q + wprs_pkg::FACT_W'(1);
					fill_e_q <= EL_W'(1);
					prev_q   <= wprs_pkg::Q30_ONE[wprs_pkg::POW_W-1:0];
				end else begin
					fill_e_q <= fill_e_q + EL_W'(1);
					prev_q   <= fill_p;
				end
			end

			// no window, drained queue, first time or time going backwards
			if (state_q == wprs_pkg::S_DECIDE) begin
				if (no_window || drained || restart) begin
					last_time_q  <= now_q;
					time_known_q <= 1'b1;
				end
				if (drained) ratio_q <= RATIO_ONE;
			end

			if (state_q == wprs_pkg::S_UPD_WR) begin
				ratio_q     <= ratio_upd;
				last_time_q <= now_q;
			end

			if (state_q == wprs_pkg::S_TGT_WR && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == wprs_pkg::S_FILL_LO || state_q == wprs_pkg::S_UPD_LO) begin
			acc_q <= prod_q;
		end
		if (item_acc) begin
			est_q    <= item.estimate_bps;
			now_q    <= item.time_ms;
			flight_q <= item.in_flight_bytes;
			queued_q <= item.queued_bytes;
			window_q <= item.window_bytes;
		end
		if (state_q == wprs_pkg::S_DECIDE) begin
			bypass_q <= no_window;
		end
		if (state_q == wprs_pkg::S_TGT_WR && out_free) begin
			res_target_q <= target_c;
			res_ratio_q  <= ratio_q;
		end
	end

	// power table memory
	always_ff @(posedge clk) begin
		if (rom_we) begin
			rom_mem[fill_k_q][fill_e_q] <= fill_p;
		end
		if (rom_re) begin
			rom_rd_q <= rom_mem[k_sel][el_sel];
		end
	end

	assign result.valid      = res_valid_q;
	assign result.target_bps = res_target_q;
	assign result.ratio_now  = res_ratio_q;

endmodule
